### rtl/core/icdf_pkg.sv
// Shared types and constants for the inverse-CDF table sampler.
package icdf_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 256;
    localparam int unsigned PROB_BITS_DEF   = 32;

    localparam int unsigned INDEX_W    = 8;
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned SIZE_REG_W = 9;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 9;

    // Word commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_MODE  = 1'b1;

    typedef struct packed {
        logic               command;
        logic [INDEX_W-1:0] entry_index;
        logic [VALUE_W-1:0] entry_value;
        logic [VALUE_W-1:0] uniform_draw;
    } t_in_word;

    typedef struct packed {
        logic [INDEX_W-1:0] picked_index;
        logic               no_match;
    } t_out_word;

    // Top level to search sequencer
    typedef struct packed {
        logic start;
        logic take;
        logic miss_mode;
    } t_search_ctrl;

    // Search sequencer to top level
    typedef struct packed {
        logic idle;
        logic done;
    } t_search_stat;

endpackage

### rtl/core/icdf_mem.sv
// Table memory: one write port, one read port, registered read data.
module icdf_mem import icdf_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int unsigned PROB_BITS   = PROB_BITS_DEF,
    localparam int unsigned IDX_W      = $clog2(TABLE_DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [IDX_W-1:0]     i_waddr,
    input  logic [PROB_BITS-1:0] i_wdata,
    input  logic [IDX_W-1:0]     i_raddr,
    output logic [PROB_BITS-1:0] o_rdata
);

    logic [PROB_BITS-1:0] r_mem [TABLE_DEPTH];
    logic [PROB_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/icdf_search.sv
// Lower-bound binary search sequencer: one table read and one compare per cycle while searching.
module icdf_search import icdf_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int unsigned PROB_BITS   = PROB_BITS_DEF,
    localparam int unsigned IDX_W      = $clog2(TABLE_DEPTH),
    localparam int unsigned CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_search_ctrl         i_ctrl,
    input  logic [CNT_W-1:0]     i_size,
    input  logic [PROB_BITS-1:0] i_draw,
    input  logic [PROB_BITS-1:0] i_rdata,
    output logic [IDX_W-1:0]     o_raddr,
    output t_search_stat         o_stat,
    output t_out_word            o_result
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_DONE   = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0]     r_lo, n_lo;
    logic [CNT_W-1:0]     r_hi, n_hi;
    logic [CNT_W-1:0]     r_size;
    logic [IDX_W-1:0]     r_mid;
    logic [PROB_BITS-1:0] r_draw;
    logic                 r_mode;
    t_out_word            r_res, n_res;
    logic [CNT_W:0]       w_sum;
    logic [IDX_W-1:0]     w_mid;

    // Narrowing step on the entry read last cycle
    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (i_rdata >= r_draw) begin
            n_hi = CNT_W'(r_mid);
        end else begin
            n_lo = CNT_W'(r_mid) + 1'b1;
        end
        w_sum = {1'b0, n_lo} + {1'b0, n_hi};
        w_mid = IDX_W'(w_sum >> 1);
    end

    // Final answer once the interval closes
    always_comb begin
        n_res = '0;
        if (n_lo < r_size) begin
            n_res.picked_index = INDEX_W'(n_lo);
        end else if (!r_mode) begin
            n_res.picked_index = INDEX_W'(r_size - 1'b1);
        end else begin
            n_res.no_match = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        o_raddr = IDX_W'(i_size >> 1);
        unique case (r_state)
            S_IDLE: begin
                if (i_ctrl.start) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_raddr = w_mid;
                if (n_lo >= n_hi) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_ctrl.take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_ctrl.start) begin
            r_lo   <= '0;
            r_hi   <= i_size;
            r_size <= i_size;
            r_draw <= i_draw;
            r_mode <= i_ctrl.miss_mode;
            r_mid  <= o_raddr;
        end else if (r_state == S_SEARCH) begin
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_mid <= o_raddr;
            r_res <= n_res;
        end
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_DONE);
    assign o_result    = r_res;

    // Assertions
    a_interval_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_lo <= r_hi))
        else $error("search interval inverted");

    a_hi_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_hi <= r_size))
        else $error("upper bound beyond table size");

    a_mid_in_interval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (CNT_W'(r_mid) < r_hi))
        else $error("probe outside search interval");

    a_miss_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res.no_match) |-> (r_res.picked_index == '0))
        else $error("flagged miss with nonzero index");

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_ctrl.start) |=> (r_state == S_SEARCH))
        else $error("draw start not taken");

endmodule

### rtl/core/inverse_cdf_table_sampler_core.sv
// Inverse-CDF table sampler top level: config registers, word handshakes, output register.
//
// Holds a table of cumulative probabilities (0.PROB_BITS fractions, all ones is 1.0)
// in a single-port-read, single-port-write synchronous RAM. A load word writes one
// entry and gives no result; indexes at or beyond TABLE_DEPTH are dropped.
// A draw word runs a lower-bound binary search for the first entry >= the uniform
// sample: accept the word and issue the first read, then the halving steps
// (ceil(log2(size+1)) steps at most, 9 for a 256-entry table), each comparing the
// entry the RAM returned for the previous probe, then the result goes into the output
// register once that register is free or being read. Only one word is worked on at a
// time; the output register lets the next word in while a result waits to be taken.
// When the sample exceeds every entry in use, miss_mode 0 returns the last index and
// miss_mode 1 returns index 0 with no_match set. Table entries have no reset value:
// a draw must only probe entries already loaded. table_size 0 acts as 1 and values
// above TABLE_DEPTH saturate. Write configuration only while the block is idle.
module inverse_cdf_table_sampler_core import icdf_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int unsigned PROB_BITS   = PROB_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input words
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    // result words
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word
);

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [SIZE_REG_W-1:0] r_table_size;
    logic                  r_miss_mode;
    logic                  r_out_valid;
    t_out_word             r_out_word;

    logic                  w_in_acc;
    logic                  w_load_ok;
    logic [31:0]           w_size_ext;
    logic [CNT_W-1:0]      w_size;
    logic [PROB_BITS-1:0]  w_rdata;
    logic [IDX_W-1:0]      w_raddr;
    t_search_ctrl          w_ctrl;
    t_search_stat          w_stat;
    t_out_word             w_result;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= SIZE_REG_W'(1);
            r_miss_mode  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TABLE_SIZE: r_table_size <= i_cfg_data[SIZE_REG_W-1:0];
                CFG_MISS_MODE:  r_miss_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Entries in use: zero acts as one, saturate at the depth
    always_comb begin
        w_size_ext = 32'(r_table_size);
        if (w_size_ext == 32'd0) begin
            w_size_ext = 32'd1;
        end
        if (w_size_ext > 32'(TABLE_DEPTH)) begin
            w_size_ext = 32'(TABLE_DEPTH);
        end
        w_size = CNT_W'(w_size_ext);
    end

    // Input side: words only enter while the sequencer is idle
    assign o_in_ready = w_stat.idle;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_load_ok  = w_in_acc && (i_in_word.command == CMD_LOAD)
                        && (32'(i_in_word.entry_index) < 32'(TABLE_DEPTH));

    assign w_ctrl.start     = w_in_acc && (i_in_word.command == CMD_DRAW);
    assign w_ctrl.take      = w_stat.done && (!r_out_valid || i_out_ready);
    assign w_ctrl.miss_mode = r_miss_mode;

    icdf_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PROB_BITS   (PROB_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_load_ok),
        .i_waddr (IDX_W'(i_in_word.entry_index)),
        .i_wdata (PROB_BITS'(i_in_word.entry_value)),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    icdf_search #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PROB_BITS   (PROB_BITS)
    ) u_search (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_size   (w_size),
        .i_draw   (PROB_BITS'(i_in_word.uniform_draw)),
        .i_rdata  (w_rdata),
        .o_raddr  (w_raddr),
        .o_stat   (w_stat),
        .o_result (w_result)
    );

    // Output register: filled when the search result is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.take) begin
            r_out_word <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
